### rtl/swcf_pkg.sv
// shared types, constants and command codes of the sliding window cluster finder
package swcf_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int TAG_BITS_DEF  = 16;

  // fixed field widths
  localparam int KEY_W    = 64;
  localparam int TAG_W    = 16;
  localparam int RANK_W   = 6;
  localparam int END_W    = 7;
  localparam int KIND_W   = 2;
  localparam int WINDOW_W = 31;
  localparam int MINC_W   = 7;
  localparam int CFG_AW   = 1;
  localparam int IN_DW    = 88;
  localparam int OUT_DW   = 96;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLUSTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_MINC   = 1'd1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_RANK,
    OP_OUT_READ,
    OP_SORT_INIT,
    OP_SORT_RD_I,
    OP_SORT_LATCH,
    OP_SORT_RD_J,
    OP_SORT_SHIFT,
    OP_SORT_PUT,
    OP_SCAN_INIT,
    OP_SCAN_RD_T,
    OP_SCAN_LATCH,
    OP_SCAN_RD_H,
    OP_HEAD_INC,
    OP_EVAL,
    OP_FLUSH_CLUSTER,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic cnt_zero;
    logic cnt_le1;
    logic i_end;
    logic j_zero;
    logic k_less;
    logic head_end;
    logic in_window;
    logic emit;
    logic best_nz;
    logic tail_end;
    logic tail_over;
  } status_t;

endpackage

### rtl/sliding_window_cluster_finder.sv
// top level of the sliding window cluster finder
// Usage:
//  Input stream (in_*): a request with mode 0 loads one tagged signed key;
//  loads are taken one per cycle while no result waits. in_tlast on a load
//  ends the run: the block then sorts the stored keys (ties keep load order)
//  and scans the sorted ranks for windows; in_tready is low until the done
//  result leaves. Mode 1 reads back the tag and key at a sorted rank.
//  Result stream (out_*): tuser carries the kind (read, cluster, done);
//  tlast marks the last result of a request. Clusters come before done.
//  A load gives no result; a read is answered from the registered memory
//  read through the result register. Sort is insertion sort in the entry
//  memory: each key is latched and moved down past larger sorted keys,
//  which shift up one rank; the scan probes head ranks for each tail rank.
//  Config (cfg_*): index 0 window, 1 min_cluster; write only while idle.
//  Reset clears counts, window and result valid, sets min_cluster to 25 and
//  keeps the memory. With out_tready low the result holds; later ones wait.
module sliding_window_cluster_finder #(
  parameter int MAX_ITEMS = swcf_pkg::MAX_ITEMS_DEF,
  parameter int TAG_BITS  = swcf_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mode[0], entry_key[64:1], item_tag[80:65], read_rank[86:81]
  input  logic [swcf_pkg::IN_DW-1:0]      in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // start_rank[5:0], end_rank[12:6], out_tag[28:13], out_key[92:29], overflow[93]
  output logic [swcf_pkg::OUT_DW-1:0]     out_tdata,
  // kind[1:0]
  output logic [swcf_pkg::KIND_W-1:0]     out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [swcf_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [swcf_pkg::WINDOW_W-1:0]   cfg_wdata
);

  swcf_pkg::cmd_t    cmd;
  swcf_pkg::status_t sts;

  logic [swcf_pkg::RANK_W-1:0]       o_start;
  logic [swcf_pkg::END_W-1:0]        o_end;
  logic [swcf_pkg::TAG_W-1:0]        o_tag;
  logic signed [swcf_pkg::KEY_W-1:0] o_key;
  logic                              o_ovf;

  swcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tdata[0]),
    .in_last   (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  swcf_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_key     (in_tdata[64:1]),
    .in_tag     (in_tdata[80:65]),
    .in_rank    (in_tdata[86:81]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_start  (o_start),
    .out_end    (o_end),
    .out_tag    (o_tag),
    .out_key    (o_key),
    .out_ovf    (o_ovf),
    .out_last   (out_tlast)
  );

  // result packing
  assign out_tdata = {2'b00, o_ovf, o_key, o_tag, o_end, o_start};

endmodule

### rtl/swcf_ctrl.sv
// controller state machine: load, read, insertion sort and window scan sequencing
module swcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_mode,
  input  logic              in_last,
  input  swcf_pkg::status_t sts,
  output swcf_pkg::cmd_t    cmd
);

  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_RD_WAIT   = 16'h0002,
    ST_SORT_INIT = 16'h0004,
    ST_SORT_LD   = 16'h0008,
    ST_SORT_LDW  = 16'h0010,
    ST_SORT_RD   = 16'h0020,
    ST_SORT_CMP  = 16'h0040,
    ST_SORT_PUT  = 16'h0080,
    ST_SCAN_INIT = 16'h0100,
    ST_SCAN_TL   = 16'h0200,
    ST_SCAN_TLW  = 16'h0400,
    ST_SCAN_HD   = 16'h0800,
    ST_SCAN_HCMP = 16'h1000,
    ST_SCAN_EVAL = 16'h2000,
    ST_SCAN_EMIT = 16'h4000,
    ST_FLUSH     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // input request taken only when idle and the result register is empty
  assign in_tready = (state_r == ST_IDLE) && !sts.out_busy;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = swcf_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_mode) begin
            cmd.op    = swcf_pkg::OP_READ_RANK;
            state_nxt = ST_RD_WAIT;
          end else begin
            cmd.op = swcf_pkg::OP_LOAD;
            if (in_last) state_nxt = ST_SORT_INIT;
          end
        end
      end
      ST_RD_WAIT: begin
        cmd.op    = swcf_pkg::OP_OUT_READ;
        state_nxt = ST_IDLE;
      end
      ST_SORT_INIT: begin
        cmd.op    = swcf_pkg::OP_SORT_INIT;
        state_nxt = sts.cnt_le1 ? ST_SCAN_INIT : ST_SORT_LD;
      end
      ST_SORT_LD: begin
        cmd.op    = swcf_pkg::OP_SORT_RD_I;
        state_nxt = ST_SORT_LDW;
      end
      ST_SORT_LDW: begin
        cmd.op    = swcf_pkg::OP_SORT_LATCH;
        state_nxt = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        if (sts.j_zero) begin
          state_nxt = ST_SORT_PUT;
        end else begin
          cmd.op    = swcf_pkg::OP_SORT_RD_J;
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (sts.k_less) begin
          cmd.op    = swcf_pkg::OP_SORT_SHIFT;
          state_nxt = ST_SORT_RD;
        end else begin
          state_nxt = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        cmd.op    = swcf_pkg::OP_SORT_PUT;
        state_nxt = sts.i_end ? ST_SCAN_INIT : ST_SORT_LD;
      end
      ST_SCAN_INIT: begin
        cmd.op    = swcf_pkg::OP_SCAN_INIT;
        state_nxt = sts.cnt_zero ? ST_FLUSH : ST_SCAN_TL;
      end
      ST_SCAN_TL: begin
        cmd.op    = swcf_pkg::OP_SCAN_RD_T;
        state_nxt = ST_SCAN_TLW;
      end
      ST_SCAN_TLW: begin
        cmd.op    = swcf_pkg::OP_SCAN_LATCH;
        state_nxt = ST_SCAN_HD;
      end
      ST_SCAN_HD: begin
        if (sts.head_end) begin
          state_nxt = ST_SCAN_EVAL;
        end else begin
          cmd.op    = swcf_pkg::OP_SCAN_RD_H;
          state_nxt = ST_SCAN_HCMP;
        end
      end
      ST_SCAN_HCMP: begin
        if (sts.in_window) begin
          cmd.op    = swcf_pkg::OP_HEAD_INC;
          state_nxt = ST_SCAN_HD;
        end else begin
          state_nxt = ST_SCAN_EVAL;
        end
      end
      ST_SCAN_EVAL: begin
        // a cluster to emit waits here until the result register is free
        if (!(sts.emit && sts.out_busy)) begin
          cmd.op = swcf_pkg::OP_EVAL;
          if (sts.emit)          state_nxt = ST_SCAN_EMIT;
          else if (sts.tail_end) state_nxt = ST_FLUSH;
          else                   state_nxt = ST_SCAN_TL;
        end
      end
      ST_SCAN_EMIT: begin
        if (!sts.out_busy) state_nxt = sts.tail_over ? ST_FLUSH : ST_SCAN_TL;
      end
      ST_FLUSH: begin
        if (!sts.out_busy) begin
          if (sts.best_nz) begin
            cmd.op = swcf_pkg::OP_FLUSH_CLUSTER;
          end else begin
            cmd.op    = swcf_pkg::OP_DONE;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/swcf_dp.sv
// datapath: entry memory, counters, compares, config and result register
module swcf_dp #(
  parameter int MAX_ITEMS = swcf_pkg::MAX_ITEMS_DEF,
  parameter int TAG_BITS  = swcf_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swcf_pkg::cmd_t                      cmd,
  output swcf_pkg::status_t                   sts,
  input  logic signed [swcf_pkg::KEY_W-1:0]   in_key,
  input  logic [swcf_pkg::TAG_W-1:0]          in_tag,
  input  logic [swcf_pkg::RANK_W-1:0]         in_rank,
  input  logic                                cfg_we,
  input  logic [swcf_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [swcf_pkg::WINDOW_W-1:0]       cfg_wdata,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic [swcf_pkg::KIND_W-1:0]         out_kind,
  output logic [swcf_pkg::RANK_W-1:0]         out_start,
  output logic [swcf_pkg::END_W-1:0]          out_end,
  output logic [swcf_pkg::TAG_W-1:0]          out_tag,
  output logic signed [swcf_pkg::KEY_W-1:0]   out_key,
  output logic                                out_ovf,
  output logic                                out_last
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W = CNT_W + swcf_pkg::MINC_W;

  typedef struct packed {
    logic signed [swcf_pkg::KEY_W-1:0] key;
    logic [TAG_BITS-1:0]               tag;
  } entry_t;

  entry_t mem [MAX_ITEMS];
  entry_t rdata_r;
  logic             rd_en, we;
  logic [IDX_W-1:0] raddr, waddr;
  entry_t           wdata;

  logic [swcf_pkg::WINDOW_W-1:0] window_r;
  logic [swcf_pkg::MINC_W-1:0]   minc_r;
  logic [CNT_W-1:0] cnt_r, i_r, j_r, tail_r, head_r, best_start_r, best_end_r;
  logic             drop_r, oob_r, out_valid_r;
  entry_t           k_r;
  logic signed [swcf_pkg::KEY_W-1:0] tkey_r;

  logic [CNT_W-1:0] run_len, best_len, jm1;
  logic [swcf_pkg::KEY_W-1:0] diff;
  logic is_long, load_out, cnt_full;

  assign jm1      = j_r - 1'b1;
  assign run_len  = head_r - tail_r;
  assign best_len = best_end_r - best_start_r;
  assign diff     = rdata_r.key - tkey_r;
  assign is_long  = CMP_W'(run_len) > CMP_W'(minc_r);
  assign cnt_full = cnt_r >= CNT_W'(MAX_ITEMS);

  // status toward the controller
  always_comb begin
    sts.out_busy  = out_valid_r;
    sts.cnt_zero  = cnt_r == '0;
    sts.cnt_le1   = cnt_r <= CNT_W'(1);
    sts.i_end     = ({1'b0, i_r} + 1'b1) >= {1'b0, cnt_r};
    sts.j_zero    = j_r == '0;
    sts.k_less    = k_r.key < rdata_r.key;
    sts.head_end  = head_r >= cnt_r;
    sts.in_window = diff < swcf_pkg::KEY_W'(window_r);
    sts.best_nz   = best_end_r != '0;
    sts.emit      = !is_long && (best_end_r != '0);
    sts.tail_end  = ({1'b0, tail_r} + 1'b1) >= {1'b0, cnt_r};
    sts.tail_over = tail_r >= cnt_r;
  end

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = j_r[IDX_W-1:0];
    wdata = k_r;
    unique case (cmd.op)
      swcf_pkg::OP_LOAD: begin
        we        = !cnt_full;
        waddr     = cnt_r[IDX_W-1:0];
        wdata.key = in_key;
        wdata.tag = TAG_BITS'(in_tag);
      end
      swcf_pkg::OP_READ_RANK: begin
        rd_en = 1'b1;
        raddr = IDX_W'(in_rank);
      end
      swcf_pkg::OP_SORT_RD_I: begin
        rd_en = 1'b1;
        raddr = i_r[IDX_W-1:0];
      end
      swcf_pkg::OP_SORT_RD_J: begin
        rd_en = 1'b1;
        raddr = jm1[IDX_W-1:0];
      end
      swcf_pkg::OP_SORT_SHIFT: begin
        we    = 1'b1;
        wdata = rdata_r;
      end
      swcf_pkg::OP_SORT_PUT: we = 1'b1;
      swcf_pkg::OP_SCAN_RD_T: begin
        rd_en = 1'b1;
        raddr = tail_r[IDX_W-1:0];
      end
      swcf_pkg::OP_SCAN_RD_H: begin
        rd_en = 1'b1;
        raddr = head_r[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[raddr];
  end

  assign load_out = (cmd.op == swcf_pkg::OP_OUT_READ) || (cmd.op == swcf_pkg::OP_DONE) ||
                    (cmd.op == swcf_pkg::OP_FLUSH_CLUSTER) ||
                    ((cmd.op == swcf_pkg::OP_EVAL) && !is_long && (best_end_r != '0));

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      minc_r       <= swcf_pkg::MINC_W'(25);
      cnt_r        <= '0;
      drop_r       <= 1'b0;
      best_start_r <= '0;
      best_end_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          swcf_pkg::CFG_WINDOW: window_r <= cfg_wdata;
          swcf_pkg::CFG_MINC:   minc_r   <= cfg_wdata[swcf_pkg::MINC_W-1:0];
          default: ;
        endcase
      end
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        swcf_pkg::OP_LOAD: begin
          if (cnt_full) drop_r <= 1'b1;
          else          cnt_r  <= cnt_r + 1'b1;
        end
        swcf_pkg::OP_SCAN_INIT, swcf_pkg::OP_FLUSH_CLUSTER: begin
          best_start_r <= '0;
          best_end_r   <= '0;
        end
        swcf_pkg::OP_EVAL: begin
          if (is_long) begin
            if (run_len > best_len) begin
              best_start_r <= tail_r;
              best_end_r   <= head_r;
            end
          end else begin
            best_start_r <= '0;
            best_end_r   <= '0;
          end
        end
        swcf_pkg::OP_DONE: begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // loop indexes and latched operands
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      swcf_pkg::OP_READ_RANK:  oob_r <= int'(in_rank) >= MAX_ITEMS;
      swcf_pkg::OP_SORT_INIT:  i_r <= CNT_W'(1);
      swcf_pkg::OP_SORT_LATCH: begin
        k_r <= rdata_r;
        j_r <= i_r;
      end
      swcf_pkg::OP_SORT_SHIFT: j_r <= jm1;
      swcf_pkg::OP_SORT_PUT:   i_r <= i_r + 1'b1;
      swcf_pkg::OP_SCAN_INIT:  tail_r <= '0;
      swcf_pkg::OP_SCAN_LATCH: begin
        tkey_r <= rdata_r.key;
        head_r <= tail_r + 1'b1;
      end
      swcf_pkg::OP_HEAD_INC:   head_r <= head_r + 1'b1;
      swcf_pkg::OP_EVAL:       tail_r <= tail_r + 1'b1;
      default: ;
    endcase
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_start <= '0;
      out_end   <= '0;
      out_tag   <= '0;
      out_key   <= '0;
      out_ovf   <= 1'b0;
      out_last  <= 1'b0;
      priority case (cmd.op)
        swcf_pkg::OP_OUT_READ: begin
          out_kind <= swcf_pkg::KIND_READ;
          out_last <= 1'b1;
          if (!oob_r) begin
            out_tag <= swcf_pkg::TAG_W'(rdata_r.tag);
            out_key <= rdata_r.key;
          end
        end
        swcf_pkg::OP_DONE: begin
          out_kind <= swcf_pkg::KIND_DONE;
          out_ovf  <= drop_r;
          out_last <= 1'b1;
        end
        default: begin
          out_kind  <= swcf_pkg::KIND_CLUSTER;
          out_start <= swcf_pkg::RANK_W'(best_start_r);
          out_end   <= swcf_pkg::END_W'(best_end_r);
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
